// ===== sv/fdf_pkg.sv =====
package fdf_pkg;

  // Default and upper bound of the decimal place count.
  localparam int MAX_PLACES_DEF = 15;
  localparam int PLACES_W = 5;

  // Reset value of the buffer capacity register.
  localparam logic [7:0] CAP_RESET = 8'd64;

  // ASCII codes used in the text.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Powers of ten that fit in 64 bits.
  function automatic logic [63:0] pow10(input logic [PLACES_W-1:0] n);
    logic [63:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/fixed_decimal_formatter.sv =====
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+----------------------------
// item in   | value_bits, places                        | start high while busy low
// results   | character, ok, last                       | result_valid, one cycle each
// config    | config_data                               | config_write, any cycle
//
// The mantissa is aligned one bit per cycle, the fraction is scaled by ten
// once per place, each of the two roundings finds its leading one by a
// one-bit-per-cycle scan, and the integer and fraction parts each go through
// a double-dabble converter. Characters then leave at one per cycle. Reset
// clears the control state and sets the capacity to 64. The receiver cannot
// stall: each result is shown for exactly one cycle, and busy falls at the
// edge that puts the final result on the ports.
module fixed_decimal_formatter #(
  parameter int MAX_PLACES = fdf_pkg::MAX_PLACES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_bits,
  input  logic [7:0]  places,
  input  logic        config_write,
  input  logic [7:0]  config_data,
  output logic        result_valid,
  output logic [7:0]  character,
  output logic        ok,
  output logic        last
);

  // Integer bits of the scaled fraction, fraction bits of the scaling register,
  // and the width of the rounding register (57 fraction bits, the lowest sticky).
  localparam int XW  = $clog2(fdf_pkg::pow10(fdf_pkg::PLACES_W'(MAX_PLACES))) + 1;
  localparam int FB  = XW + 60;
  localparam int AW  = XW + FB;
  localparam int SW  = 64 + FB;
  localparam int RW  = XW + 58;
  localparam int RIW = $clog2(RW);
  localparam int FPW = XW + 1;
  localparam int CW  = (FPW > 64) ? FPW : 64;
  localparam logic [10:0] ZERO_EXP = 11'(1075 - FB);
  localparam logic [RW-1:0] HALF = RW'(1) << 56;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_ALIGN = 5'd1;
  localparam logic [4:0] ST_MUL   = 5'd2;
  localparam logic [4:0] ST_SCAN  = 5'd3;
  localparam logic [4:0] ST_ROUND = 5'd4;
  localparam logic [4:0] ST_ADD   = 5'd5;
  localparam logic [4:0] ST_HALF  = 5'd6;
  localparam logic [4:0] ST_CARRY = 5'd7;
  localparam logic [4:0] ST_PREP  = 5'd8;
  localparam logic [4:0] ST_CONVI = 5'd9;
  localparam logic [4:0] ST_CONVF = 5'd10;
  localparam logic [4:0] ST_IDIG  = 5'd11;
  localparam logic [4:0] ST_CHECK = 5'd12;
  localparam logic [4:0] ST_SIGN  = 5'd13;
  localparam logic [4:0] ST_INT   = 5'd14;
  localparam logic [4:0] ST_DOT   = 5'd15;
  localparam logic [4:0] ST_FRAC  = 5'd16;
  localparam logic [4:0] ST_NUL   = 5'd17;
  localparam logic [4:0] ST_FAIL  = 5'd18;

  logic [4:0]                   state;
  logic [7:0]                   cap;
  logic                         neg;
  logic [fdf_pkg::PLACES_W-1:0] plc;
  logic                         shl;
  logic [SW-1:0]                s;
  logic [AW-1:0]                a;
  logic [RW-1:0]                r;
  logic [7:0]                   cnt;
  logic [RIW-1:0]               lpos;
  logic                         up;
  logic                         pass;
  logic [FPW-1:0]               fp;
  logic [63:0]                  cv;
  logic [79:0]                  bcd;
  logic [79:0]                  ibcd;
  logic [4:0]                   idig;

  logic [10:0]    ex;
  logic [RIW-1:0] ridx;
  logic [RW-1:0]  keep_mask;
  logic [RW-1:0]  low_mask;
  logic [RW-1:0]  rounded;
  logic [79:0]    bcd_adj;
  logic [6:0]     dsel;
  logic [3:0]     int_digit;
  logic [3:0]     frac_digit;
  logic [5:0]     required;
  logic [CW-1:0]  fp_ext;
  logic [CW-1:0]  scale_ext;

  assign busy = (state != ST_IDLE);
  assign ex   = value_bits[62:52];
  assign ridx = cnt[RIW-1:0];

  // Rounding to 53 significant bits at position lpos, ties to even.
  assign keep_mask = ~((RW'(1) << lpos) - RW'(1));
  assign low_mask  = (RW'(1) << (lpos - RIW'(1))) - RW'(1);
  assign rounded   = (r & keep_mask) + (up ? (RW'(1) << lpos) : RW'(0));

  // Double-dabble adjust: every BCD digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < 20; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign dsel       = 7'({cnt[4:0] - 5'd1, 2'b00});
  assign int_digit  = ibcd[dsel +: 4];
  assign frac_digit = bcd[dsel +: 4];

  assign required = 6'(neg) + 6'(idig) + ((plc != '0) ? 6'(plc) + 6'd1 : 6'd0) + 6'd1;
  assign fp_ext    = CW'(fp);
  assign scale_ext = CW'(fdf_pkg::pow10(plc));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cap          <= fdf_pkg::CAP_RESET;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (config_write) begin
        cap <= config_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            neg <= value_bits[63];
            plc <= fdf_pkg::PLACES_W'(places);
            if (ex == 11'h7FF || places > 8'(MAX_PLACES) || ex >= 11'd1087) begin
              state <= ST_FAIL;
            end else begin
              // Magnitudes too small to matter after scaling become zero.
              if (ex < ZERO_EXP) begin
                s   <= '0;
                cnt <= 8'd0;
              end else begin
                s <= {64'd0, 1'b1, value_bits[51:0], (FB-53)'(0)};
                if (ex >= 11'd1023) begin
                  shl <= 1'b1;
                  cnt <= 8'(ex - 11'd1022);
                end else begin
                  shl <= 1'b0;
                  cnt <= 8'(11'd1022 - ex);
                end
              end
              state <= ST_ALIGN;
            end
          end
        end
        ST_ALIGN: begin
          if (cnt == 8'd0) begin
            a   <= {XW'(0), s[FB-1:0]};
            cnt <= 8'(plc);
            if (plc == '0) begin
              fp    <= '0;
              state <= ST_CARRY;
            end else begin
              state <= ST_MUL;
            end
          end else begin
            s   <= shl ? (s << 1) : (s >> 1);
            cnt <= cnt - 8'd1;
          end
        end
        ST_MUL: begin
          if (cnt == 8'd0) begin
            r     <= {1'b0, a[AW-1:FB], a[FB-1:FB-56], |a[FB-57:0]};
            cnt   <= 8'(RW - 1);
            pass  <= 1'b0;
            state <= ST_SCAN;
          end else begin
            a   <= (a << 3) + (a << 1);
            cnt <= cnt - 8'd1;
          end
        end
        ST_SCAN: begin
          // Leading-one search; a product below one quarter always gives a zero
          // fraction, so the first search stops there; the second stops at one half.
          if (r[ridx]) begin
            lpos  <= ridx - RIW'(52);
            state <= ST_ROUND;
          end else if (ridx == (pass ? RIW'(56) : RIW'(55))) begin
            fp    <= '0;
            state <= ST_CARRY;
          end else begin
            cnt <= cnt - 8'd1;
          end
        end
        ST_ROUND: begin
          up    <= r[lpos - RIW'(1)] & (r[lpos] | (|(r & low_mask)));
          state <= ST_ADD;
        end
        ST_ADD: begin
          r <= rounded;
          if (pass) begin
            fp    <= rounded[RW-1:57];
            state <= ST_CARRY;
          end else begin
            state <= ST_HALF;
          end
        end
        ST_HALF: begin
          r     <= r + HALF;
          pass  <= 1'b1;
          cnt   <= 8'(RW - 1);
          state <= ST_SCAN;
        end
        ST_CARRY: begin
          if (fp_ext >= scale_ext) begin
            if (&s[SW-1:FB]) begin
              state <= ST_FAIL;
            end else begin
              s[SW-1:FB] <= s[SW-1:FB] + 64'd1;
              fp         <= '0;
              state      <= ST_PREP;
            end
          end else begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          cv    <= s[SW-1:FB];
          bcd   <= '0;
          cnt   <= 8'd64;
          state <= ST_CONVI;
        end
        ST_CONVI: begin
          if (cnt == 8'd0) begin
            ibcd  <= bcd;
            cv    <= 64'(fp);
            bcd   <= '0;
            cnt   <= 8'd64;
            state <= ST_CONVF;
          end else begin
            {bcd, cv} <= {bcd_adj, cv} << 1;
            cnt       <= cnt - 8'd1;
          end
        end
        ST_CONVF: begin
          if (cnt == 8'd0) begin
            cnt   <= 8'd20;
            state <= ST_IDIG;
          end else begin
            {bcd, cv} <= {bcd_adj, cv} << 1;
            cnt       <= cnt - 8'd1;
          end
        end
        ST_IDIG: begin
          // Drop leading zero digits of the integer part, keeping at least one.
          if (cnt > 8'd1 && int_digit == 4'd0) begin
            cnt <= cnt - 8'd1;
          end else begin
            idig  <= cnt[4:0];
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cnt <= 8'(idig);
          if ({2'b00, required} > cap) begin
            state <= ST_FAIL;
          end else if (neg) begin
            state <= ST_SIGN;
          end else begin
            state <= ST_INT;
          end
        end
        ST_SIGN: begin
          result_valid <= 1'b1;
          character    <= fdf_pkg::CHAR_MINUS;
          ok           <= 1'b1;
          last         <= 1'b0;
          state        <= ST_INT;
        end
        ST_INT: begin
          result_valid <= 1'b1;
          character    <= fdf_pkg::CHAR_ZERO + 8'(int_digit);
          ok           <= 1'b1;
          last         <= 1'b0;
          cnt          <= cnt - 8'd1;
          if (cnt == 8'd1) begin
            state <= (plc != '0) ? ST_DOT : ST_NUL;
          end
        end
        ST_DOT: begin
          result_valid <= 1'b1;
          character    <= fdf_pkg::CHAR_DOT;
          ok           <= 1'b1;
          last         <= 1'b0;
          cnt          <= 8'(plc);
          state        <= ST_FRAC;
        end
        ST_FRAC: begin
          result_valid <= 1'b1;
          character    <= fdf_pkg::CHAR_ZERO + 8'(frac_digit);
          ok           <= 1'b1;
          last         <= 1'b0;
          cnt          <= cnt - 8'd1;
          if (cnt == 8'd1) begin
            state <= ST_NUL;
          end
        end
        ST_NUL: begin
          result_valid <= 1'b1;
          character    <= fdf_pkg::CHAR_NUL;
          ok           <= 1'b1;
          last         <= 1'b1;
          state        <= ST_IDLE;
        end
        ST_FAIL: begin
          result_valid <= 1'b1;
          character    <= fdf_pkg::CHAR_NUL;
          ok           <= 1'b0;
          last         <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
